@@ hw/rtl/joint_hierarchy_pose_composer_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the joint hierarchy pose composer checker
// ---------------------------------------------------------------------------
`ifndef JOINT_HIERARCHY_POSE_COMPOSER_DEFINES_SVH
`define JOINT_HIERARCHY_POSE_COMPOSER_DEFINES_SVH

// check a property while out of reset
`define JHPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check a property on every edge, reset included
`define JHPC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ hw/rtl/jhpc_pkg.sv @@
// ---------------------------------------------------------------------------
// jhpc_pkg
// Shared types, constants and helpers of the joint hierarchy pose composer.
// ---------------------------------------------------------------------------
package jhpc_pkg;

  localparam int DEF_MAX_JOINTS = 255;
  localparam int DEF_FRAC_BITS  = 16;
  localparam logic [7:0] NO_PARENT = 8'hFF;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_QMUL,
    OP_RCALC,
    OP_LMUL,
    OP_CMUL,
    OP_COPY,
    OP_WRITE,
    OP_EMIT
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] i;
    logic [1:0] j;
    logic [1:0] k;
  } cmd_t;

  typedef struct packed {
    logic use_parent;
    logic store_ok;
    logic slot_free;
  } status_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

@@ hw/rtl/jhpc_datapath.sv @@
// ---------------------------------------------------------------------------
// jhpc_datapath
// Operand registers, one shared 32x32 multiplier, rounding and accumulation,
// the model matrix memory and the output row register.
// ---------------------------------------------------------------------------
module jhpc_datapath import jhpc_pkg::*; #(
  parameter int MAX_JOINTS = DEF_MAX_JOINTS,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  cmd_t               cmd_i,
  output status_t            st_o,
  input  logic signed [31:0] trans_x_i,
  input  logic signed [31:0] trans_y_i,
  input  logic signed [31:0] trans_z_i,
  input  logic signed [31:0] rot_x_i,
  input  logic signed [31:0] rot_y_i,
  input  logic signed [31:0] rot_z_i,
  input  logic signed [31:0] rot_w_i,
  input  logic signed [31:0] scale_x_i,
  input  logic signed [31:0] scale_y_i,
  input  logic signed [31:0] scale_z_i,
  input  logic [7:0]         parent_joint_i,
  input  logic               first_joint_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         row_number_o,
  output logic signed [31:0] col_0_o,
  output logic signed [31:0] col_1_o,
  output logic signed [31:0] col_2_o,
  output logic signed [31:0] col_3_o,
  output logic [7:0]         joint_number_o,
  output logic               parent_error_o,
  output logic               scale_error_o,
  output logic               last_row_o
);

  localparam int CW    = $clog2(MAX_JOINTS + 1);
  localparam int CMPW  = (CW > 8) ? CW : 8;
  localparam int DEPTH = MAX_JOINTS * 12;
  localparam int AW    = $clog2(DEPTH);
  localparam logic signed [31:0] ONE  = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

  logic [CW-1:0]      cnt_q, idx_n;
  logic [CMPW-1:0]    idx_ext;
  logic [AW-1:0]      own_base_q, par_base_q;
  logic               use_parent_q, store_ok_q;
  logic [7:0]         jn_q;
  logic               perr_q, serr_q;

  logic signed [31:0] q_q [4];
  logic signed [31:0] s_q [3];
  logic signed [31:0] qp_q [3][3];
  logic signed [31:0] r_q [3][3];
  logic signed [31:0] l_q [3][4];
  logic signed [31:0] m_q [3][4];

  logic signed [31:0] op_a_d, op_b_d, op_a_q, op_b_q, a_eff, f;
  logic signed [63:0] prod_q;
  logic signed [34:0] acc_q, acc_n;
  cmd_t               tag1_q, tag2_q;

  logic [31:0]        mem [DEPTH];
  logic [31:0]        rdata_q;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic               slot_free, emit;

  assign idx_n   = first_joint_i ? '0 : cnt_q;
  assign idx_ext = CMPW'(idx_n);

  // joint counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load_i) begin
      cnt_q <= (idx_n < CW'(MAX_JOINTS)) ? idx_n + CW'(1) : CW'(MAX_JOINTS);
    end
  end

  // capture the joint word
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      q_q[0]       <= rot_x_i;
      q_q[1]       <= rot_y_i;
      q_q[2]       <= rot_z_i;
      q_q[3]       <= rot_w_i;
      s_q[0]       <= scale_x_i;
      s_q[1]       <= scale_y_i;
      s_q[2]       <= scale_z_i;
      jn_q         <= idx_ext[7:0];
      store_ok_q   <= idx_n < CW'(MAX_JOINTS);
      use_parent_q <= (parent_joint_i != NO_PARENT) && (CMPW'(parent_joint_i) < idx_ext);
      perr_q       <= (parent_joint_i != NO_PARENT) && !(CMPW'(parent_joint_i) < idx_ext);
      serr_q       <= (scale_x_i <= 0) || (scale_y_i <= 0) || (scale_z_i <= 0);
      own_base_q   <= AW'({idx_n, 3'b000}) + AW'({idx_n, 2'b00});
      par_base_q   <= AW'({parent_joint_i, 3'b000}) + AW'({parent_joint_i, 2'b00});
    end
  end

  // operand select
  always_comb begin
    op_a_d = '0;
    op_b_d = '0;
    unique case (cmd_i.op)
      OP_QMUL: begin
        unique case (cmd_i.i)
          2'd0: begin
            op_a_d = q_q[cmd_i.j];
            op_b_d = q_q[cmd_i.j];
          end
          2'd1: begin
            op_a_d = (cmd_i.j == 2'd2) ? q_q[1] : q_q[0];
            op_b_d = (cmd_i.j == 2'd0) ? q_q[1] : q_q[2];
          end
          default: begin
            op_a_d = q_q[cmd_i.j];
            op_b_d = q_q[3];
          end
        endcase
      end
      OP_LMUL: begin
        op_a_d = r_q[cmd_i.i][cmd_i.j];
        op_b_d = s_q[cmd_i.j];
      end
      OP_CMUL: begin
        // the translation word of the parent rides through times one
        op_b_d = (cmd_i.k == 2'd3) ? ONE : l_q[cmd_i.k][cmd_i.j];
      end
      default: ;
    endcase
  end

  assign a_eff = (tag1_q.op == OP_CMUL) ? $signed(rdata_q) : op_a_q;
  assign f     = sat32((prod_q + HALF) >>> FRAC_BITS);
  assign acc_n = ((tag2_q.k == 2'd0) ? 35'sd0 : acc_q) + 35'(f);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '{op: OP_NONE, default: '0};
      tag2_q <= '{op: OP_NONE, default: '0};
    end else begin
      tag1_q <= cmd_i;
      tag2_q <= tag1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    op_a_q <= op_a_d;
    op_b_q <= op_b_d;
    prod_q <= a_eff * op_b_q;
    if (load_i) begin
      l_q[0][3] <= trans_x_i;
      l_q[1][3] <= trans_y_i;
      l_q[2][3] <= trans_z_i;
    end
    unique case (tag2_q.op)
      OP_QMUL: qp_q[tag2_q.i][tag2_q.j] <= f;
      OP_LMUL: l_q[tag2_q.i][tag2_q.j] <= f;
      OP_CMUL: begin
        acc_q <= acc_n;
        if ((tag2_q.j == 2'd3) ? (tag2_q.k == 2'd3) : (tag2_q.k == 2'd2)) begin
          m_q[tag2_q.i][tag2_q.j] <= sat32(64'(acc_n));
        end
      end
      default: ;
    endcase
    if (cmd_i.op == OP_RCALC) begin
      // qp rows: {xx,yy,zz}, {xy,xz,yz}, {xw,yw,zw}
      r_q[0][0] <= sat32(64'(ONE) - 64'sd2 * (64'(qp_q[0][1]) + 64'(qp_q[0][2])));
      r_q[0][1] <= sat32(64'sd2 * (64'(qp_q[1][0]) - 64'(qp_q[2][2])));
      r_q[0][2] <= sat32(64'sd2 * (64'(qp_q[1][1]) + 64'(qp_q[2][1])));
      r_q[1][0] <= sat32(64'sd2 * (64'(qp_q[1][0]) + 64'(qp_q[2][2])));
      r_q[1][1] <= sat32(64'(ONE) - 64'sd2 * (64'(qp_q[0][0]) + 64'(qp_q[0][2])));
      r_q[1][2] <= sat32(64'sd2 * (64'(qp_q[1][2]) - 64'(qp_q[2][0])));
      r_q[2][0] <= sat32(64'sd2 * (64'(qp_q[1][1]) - 64'(qp_q[2][1])));
      r_q[2][1] <= sat32(64'sd2 * (64'(qp_q[1][2]) + 64'(qp_q[2][0])));
      r_q[2][2] <= sat32(64'(ONE) - 64'sd2 * (64'(qp_q[0][0]) + 64'(qp_q[0][1])));
    end
    if (cmd_i.op == OP_COPY) begin
      m_q <= l_q;
    end
  end

  // model matrix memory
  assign rd_addr = par_base_q + AW'({cmd_i.i, cmd_i.k});
  assign wr_addr = own_base_q + AW'({cmd_i.i, cmd_i.j});

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_WRITE) begin
      mem[wr_addr] <= m_q[cmd_i.i][cmd_i.j];
    end
    rdata_q <= mem[rd_addr];
  end

  // output row register
  assign slot_free = !out_valid_o || out_ready_i;
  assign emit      = (cmd_i.op == OP_EMIT) && slot_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (emit) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      row_number_o   <= cmd_i.i;
      col_0_o        <= m_q[cmd_i.i][0];
      col_1_o        <= m_q[cmd_i.i][1];
      col_2_o        <= m_q[cmd_i.i][2];
      col_3_o        <= m_q[cmd_i.i][3];
      joint_number_o <= jn_q;
      parent_error_o <= perr_q;
      scale_error_o  <= serr_q;
      last_row_o     <= cmd_i.i == 2'd2;
    end
  end

  assign st_o = '{use_parent: use_parent_q, store_ok: store_ok_q, slot_free: slot_free};

endmodule

@@ hw/rtl/jhpc_ctrl.sv @@
// ---------------------------------------------------------------------------
// jhpc_ctrl
// Sequencer that walks one joint through the multiply phases, the store
// write when the joint number fits the store, and the three row words.
// ---------------------------------------------------------------------------
module jhpc_ctrl import jhpc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output cmd_t    cmd_o,
  input  status_t st_i
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_QMUL, ST_QWAIT, ST_RCALC, ST_LMUL, ST_LWAIT,
    ST_COPY, ST_CMUL, ST_CWAIT, ST_WRITE, ST_OUT
  } state_e;

  state_e state_q;
  logic   wait_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      wait_q     <= 1'b0;
      in_ready_o <= 1'b1;
      cmd_o      <= '{op: OP_NONE, default: '0};
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            in_ready_o <= 1'b0;
            state_q    <= ST_QMUL;
            cmd_o      <= '{op: OP_QMUL, default: '0};
          end
        end
        ST_QMUL, ST_LMUL: begin
          if (cmd_o.i == 2'd2 && cmd_o.j == 2'd2) begin
            cmd_o   <= '{op: OP_NONE, default: '0};
            wait_q  <= 1'b1;
            state_q <= (state_q == ST_QMUL) ? ST_QWAIT : ST_LWAIT;
          end else if (cmd_o.j == 2'd2) begin
            cmd_o.i <= cmd_o.i + 2'd1;
            cmd_o.j <= 2'd0;
          end else begin
            cmd_o.j <= cmd_o.j + 2'd1;
          end
        end
        // drain the two multiplier stages
        ST_QWAIT: begin
          wait_q <= 1'b0;
          if (!wait_q) begin
            cmd_o   <= '{op: OP_RCALC, default: '0};
            state_q <= ST_RCALC;
          end
        end
        ST_RCALC: begin
          cmd_o   <= '{op: OP_LMUL, default: '0};
          state_q <= ST_LMUL;
        end
        ST_LWAIT: begin
          wait_q <= 1'b0;
          if (!wait_q) begin
            if (st_i.use_parent) begin
              cmd_o   <= '{op: OP_CMUL, default: '0};
              state_q <= ST_CMUL;
            end else begin
              cmd_o   <= '{op: OP_COPY, default: '0};
              state_q <= ST_COPY;
            end
          end
        end
        ST_CMUL: begin
          if ((cmd_o.j == 2'd3) ? (cmd_o.k != 2'd3) : (cmd_o.k != 2'd2)) begin
            cmd_o.k <= cmd_o.k + 2'd1;
          end else if (cmd_o.j != 2'd3) begin
            cmd_o.k <= 2'd0;
            cmd_o.j <= cmd_o.j + 2'd1;
          end else if (cmd_o.i != 2'd2) begin
            cmd_o.k <= 2'd0;
            cmd_o.j <= 2'd0;
            cmd_o.i <= cmd_o.i + 2'd1;
          end else begin
            cmd_o   <= '{op: OP_NONE, default: '0};
            wait_q  <= 1'b1;
            state_q <= ST_CWAIT;
          end
        end
        ST_COPY, ST_CWAIT: begin
          wait_q <= 1'b0;
          if (state_q == ST_COPY || !wait_q) begin
            if (st_i.store_ok) begin
              cmd_o   <= '{op: OP_WRITE, default: '0};
              state_q <= ST_WRITE;
            end else begin
              cmd_o   <= '{op: OP_EMIT, default: '0};
              state_q <= ST_OUT;
            end
          end
        end
        ST_WRITE: begin
          if (cmd_o.i == 2'd2 && cmd_o.j == 2'd3) begin
            cmd_o   <= '{op: OP_EMIT, default: '0};
            state_q <= ST_OUT;
          end else if (cmd_o.j == 2'd3) begin
            cmd_o.i <= cmd_o.i + 2'd1;
            cmd_o.j <= 2'd0;
          end else begin
            cmd_o.j <= cmd_o.j + 2'd1;
          end
        end
        ST_OUT: begin
          // advance only when the row register takes the word
          if (st_i.slot_free) begin
            if (cmd_o.i == 2'd2) begin
              cmd_o      <= '{op: OP_NONE, default: '0};
              in_ready_o <= 1'b1;
              state_q    <= ST_IDLE;
            end else begin
              cmd_o.i <= cmd_o.i + 2'd1;
            end
          end
        end
        default: begin
          state_q    <= ST_IDLE;
          in_ready_o <= 1'b1;
          cmd_o      <= '{op: OP_NONE, default: '0};
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/joint_hierarchy_pose_composer.sv @@
// ---------------------------------------------------------------------------
// joint_hierarchy_pose_composer
// Forward kinematics over a TRS skeleton: local matrix T*R(q)*S, composed
// with the stored parent model matrix if there is one, stored and sent out row by row.
// ---------------------------------------------------------------------------
//  channel | direction | handshake             | word
//  in      | input     | in_valid_i/in_ready_o  | one joint (TRS, parent, first)
//  out     | output    | out_valid_o/out_ready_i| one matrix row
//
//  A joint with a parent takes longer than one without, and row stalls add time:
//  one shared 32x32 multiplier runs 9 quaternion, 9 local and 39 compose
//  steps, and the store takes one 32-bit word a cycle (12 per joint).
//  Reset clears the joint counter; the matrix store needs no clearing.
//  A stalled row word holds; the next joint is taken once row 2 is loaded.
// ---------------------------------------------------------------------------
module joint_hierarchy_pose_composer import jhpc_pkg::*; #(
  parameter int MAX_JOINTS = DEF_MAX_JOINTS,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] trans_x_i,
  input  logic signed [31:0] trans_y_i,
  input  logic signed [31:0] trans_z_i,
  input  logic signed [31:0] rot_x_i,
  input  logic signed [31:0] rot_y_i,
  input  logic signed [31:0] rot_z_i,
  input  logic signed [31:0] rot_w_i,
  input  logic signed [31:0] scale_x_i,
  input  logic signed [31:0] scale_y_i,
  input  logic signed [31:0] scale_z_i,
  input  logic [7:0]         parent_joint_i,
  input  logic               first_joint_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         row_number_o,
  output logic signed [31:0] col_0_o,
  output logic signed [31:0] col_1_o,
  output logic signed [31:0] col_2_o,
  output logic signed [31:0] col_3_o,
  output logic [7:0]         joint_number_o,
  output logic               parent_error_o,
  output logic               scale_error_o,
  output logic               last_row_o
);

  cmd_t    cmd;
  status_t st;

  jhpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd),
    .st_i       (st)
  );

  jhpc_datapath #(
    .MAX_JOINTS (MAX_JOINTS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (in_valid_i && in_ready_o),
    .cmd_i          (cmd),
    .st_o           (st),
    .trans_x_i      (trans_x_i),
    .trans_y_i      (trans_y_i),
    .trans_z_i      (trans_z_i),
    .rot_x_i        (rot_x_i),
    .rot_y_i        (rot_y_i),
    .rot_z_i        (rot_z_i),
    .rot_w_i        (rot_w_i),
    .scale_x_i      (scale_x_i),
    .scale_y_i      (scale_y_i),
    .scale_z_i      (scale_z_i),
    .parent_joint_i (parent_joint_i),
    .first_joint_i  (first_joint_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .row_number_o   (row_number_o),
    .col_0_o        (col_0_o),
    .col_1_o        (col_1_o),
    .col_2_o        (col_2_o),
    .col_3_o        (col_3_o),
    .joint_number_o (joint_number_o),
    .parent_error_o (parent_error_o),
    .scale_error_o  (scale_error_o),
    .last_row_o     (last_row_o)
  );

endmodule

@@ hw/rtl/jhpc_checker.sv @@
// ---------------------------------------------------------------------------
// jhpc_checker
// Port-level checks of the pose composer, bound to the top level.
// ---------------------------------------------------------------------------
`include "joint_hierarchy_pose_composer_defines.svh"

module jhpc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  row_number_o,
  input logic [31:0] col_0_o,
  input logic        last_row_o
);

  `JHPC_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(col_0_o), "row word dropped or changed under stall")
  `JHPC_ASSERT(a_last_row, out_valid_o |-> (last_row_o == (row_number_o == 2'd2)), "last_row does not match row 2")
  `JHPC_ASSERT(a_busy, in_valid_i && in_ready_o |=> !in_ready_o, "joint taken while one is in work")
  `JHPC_ASSERT(a_row0_busy, out_valid_o && out_ready_i && row_number_o == 2'd0 |=> !in_ready_o, "ready before rows of joint are out")
  // the first reset edge may find the flops still unknown, so the state is checked at the following edge
  `JHPC_ASSERT_ALWAYS(a_reset, !rst_ni |=> !out_valid_o && in_ready_o, "reset state wrong")

endmodule

bind joint_hierarchy_pose_composer jhpc_checker u_jhpc_checker (.*);
